FILE: design/arpa_pkg.sv
// Package for the address range pool allocator.
// Holds table sizes, command and status codes, and the controller state type.
// No dependencies.
`default_nettype none
package arpa_pkg;
  localparam int MaxRanges = 64;
  localparam int IdxW      = $clog2(MaxRanges);
  localparam int CntW      = $clog2(MaxRanges + 1);
  localparam int AddrW     = 32;

  localparam logic [1:0] CmdInit     = 2'd0;
  localparam logic [1:0] CmdAllocAny = 2'd1;
  localparam logic [1:0] CmdAllocReq = 2'd2;
  localparam logic [1:0] CmdUnused   = 2'd3;

  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StNotFree  = 2'd1;
  localparam logic [1:0] StBadRange = 2'd2;
  localparam logic [1:0] StFull     = 2'd3;

  localparam logic [2:0] RegPoolFirst = 3'd0;
  localparam logic [2:0] RegPoolLast  = 3'd4;

  typedef struct packed {
    logic [AddrW-1:0] first;
    logic [AddrW-1:0] last;
  } range_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD,
    S_CHK,
    S_DN_RD,
    S_DN_WR,
    S_UP_RD,
    S_UP_WR,
    S_SPL_LO,
    S_SPL_HI,
    S_DONE
  } state_e;
endpackage
`default_nettype wire

FILE: design/address_range_pool_allocator_unit.sv
// Address range pool allocator top level: APB registers, controller, range table.
// Init and rejected items go straight to the result; allocations check table entries
// in turn, then move entries if a range is dropped or split, and write a split's halves.
// One item at a time; the range table RAM's single read port sets the pace.
// Reset empties the table (count zero); RAM contents are not cleared.
// Depends on arpa_pkg and arpa_range_ram.
`default_nettype none
module address_range_pool_allocator_unit (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [2:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire  [1:0]  command_i,
  input  wire  [31:0] request_address_i,
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic [1:0]  status_o,
  output logic [31:0] granted_address_o
);
  import arpa_pkg::*;

  logic [AddrW-1:0] pool_first_q, pool_last_q;
  state_e           state_q, state_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [IdxW-1:0]  idx_q, idx_d;
  logic [CntW-1:0]  k_q, k_d;
  logic             any_q, any_d;
  logic [AddrW-1:0] req_q, req_d;
  logic [AddrW-1:0] addr_q, addr_d;
  range_t           hit_q, hit_d;
  logic [1:0]       res_st_q, res_st_d;
  logic [AddrW-1:0] res_addr_q, res_addr_d;
  logic             out_valid_q;
  logic [1:0]       out_st_q;
  logic [AddrW-1:0] out_addr_q;

  logic             we;
  logic [IdxW-1:0]  waddr, raddr;
  range_t           wdata, rdata;
  logic             in_acc, out_free, hit;
  logic [AddrW-1:0] hit_addr;
  logic [CntW-1:0]  idx_ext;

  arpa_range_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // APB registers
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_first_q <= '0;
      pool_last_q  <= '0;
    end else if (psel && penable && pwrite) begin
      if (paddr == RegPoolFirst) pool_first_q <= pwdata;
      if (paddr == RegPoolLast) pool_last_q  <= pwdata;
    end
  end
  always_comb begin
    prdata = '0;
    if (paddr == RegPoolFirst) prdata = pool_first_q;
    if (paddr == RegPoolLast) prdata = pool_last_q;
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && (state_q == S_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign idx_ext    = CntW'(idx_q);
  assign hit_addr   = any_q ? rdata.first : req_q;
  assign hit        = any_q || (rdata.first <= req_q && req_q <= rdata.last);

  // next state and bookkeeping
  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    idx_d      = idx_q;
    k_d        = k_q;
    any_d      = any_q;
    req_d      = req_q;
    addr_d     = addr_q;
    hit_d      = hit_q;
    res_st_d   = res_st_q;
    res_addr_d = res_addr_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          idx_d      = '0;
          req_d      = request_address_i;
          any_d      = (command_i == CmdAllocAny);
          res_addr_d = '0;
          res_st_d   = StNotFree;
          state_d    = S_DONE;
          if (command_i == CmdInit) begin
            if (pool_first_q > pool_last_q) begin
              res_st_d = StBadRange;
            end else begin
              res_st_d = StOk;
              count_d  = CntW'(1);
            end
          end else if ((command_i == CmdAllocAny || command_i == CmdAllocReq)
                       && count_q != '0) begin
            state_d = S_RD;
          end
        end
      end
      S_RD: state_d = S_CHK;
      S_CHK: begin
        if (!hit) begin
          if (idx_ext + CntW'(1) == count_q) begin
            state_d = S_DONE;
          end else begin
            idx_d   = idx_q + IdxW'(1);
            state_d = S_RD;
          end
        end else begin
          addr_d     = hit_addr;
          hit_d      = rdata;
          res_st_d   = StOk;
          res_addr_d = hit_addr;
          state_d    = S_DONE;
          if (rdata.first == rdata.last) begin
            if (idx_ext + CntW'(1) < count_q) begin
              k_d     = idx_ext;
              state_d = S_DN_RD;
            end else begin
              count_d = count_q - CntW'(1);
            end
          end else if (hit_addr != rdata.first && hit_addr != rdata.last) begin
            if (count_q == CntW'(MaxRanges)) begin
              res_st_d   = StFull;
              res_addr_d = '0;
            end else if (count_q > idx_ext + CntW'(1)) begin
              k_d     = count_q;
              state_d = S_UP_RD;
            end else begin
              state_d = S_SPL_LO;
            end
          end
        end
      end
      S_DN_RD: state_d = S_DN_WR;
      S_DN_WR: begin
        if (k_q + CntW'(2) == count_q) begin
          count_d = count_q - CntW'(1);
          state_d = S_DONE;
        end else begin
          k_d     = k_q + CntW'(1);
          state_d = S_DN_RD;
        end
      end
      S_UP_RD: state_d = S_UP_WR;
      S_UP_WR: begin
        k_d = k_q - CntW'(1);
        if (k_q - CntW'(1) > idx_ext + CntW'(1)) state_d = S_UP_RD;
        else state_d = S_SPL_LO;
      end
      S_SPL_LO: state_d = S_SPL_HI;
      S_SPL_HI: begin
        count_d = count_q + CntW'(1);
        state_d = S_DONE;
      end
      S_DONE: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // table port control
  always_comb begin
    we    = 1'b0;
    waddr = idx_q;
    wdata = hit_q;
    raddr = idx_q;
    unique case (state_q)
      S_IDLE: begin
        waddr = '0;
        wdata = '{first: pool_first_q, last: pool_last_q};
        we    = in_acc && command_i == CmdInit && !(pool_first_q > pool_last_q);
      end
      S_CHK: begin
        wdata = rdata;
        if (hit && rdata.first != rdata.last) begin
          if (hit_addr == rdata.first) begin
            we          = 1'b1;
            wdata.first = rdata.first + AddrW'(1);
          end else if (hit_addr == rdata.last) begin
            we         = 1'b1;
            wdata.last = rdata.last - AddrW'(1);
          end
        end
      end
      S_DN_RD: raddr = IdxW'(k_q + CntW'(1));
      S_DN_WR: begin
        we    = 1'b1;
        waddr = k_q[IdxW-1:0];
        wdata = rdata;
      end
      S_UP_RD: raddr = IdxW'(k_q - CntW'(1));
      S_UP_WR: begin
        we    = 1'b1;
        waddr = k_q[IdxW-1:0];
        wdata = rdata;
      end
      S_SPL_LO: begin
        we    = 1'b1;
        wdata = '{first: hit_q.first, last: addr_q - AddrW'(1)};
      end
      S_SPL_HI: begin
        we    = 1'b1;
        waddr = idx_q + IdxW'(1);
        wdata = '{first: addr_q + AddrW'(1), last: hit_q.last};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (state_q == S_DONE && out_free) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    k_q        <= k_d;
    any_q      <= any_d;
    req_q      <= req_d;
    addr_q     <= addr_d;
    hit_q      <= hit_d;
    res_st_q   <= res_st_d;
    res_addr_q <= res_addr_d;
    if (state_q == S_DONE && out_free) begin
      out_st_q   <= res_st_q;
      out_addr_q <= res_addr_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = out_st_q;
  assign granted_address_o = out_addr_q;
endmodule
`default_nettype wire

FILE: design/arpa_range_ram.sv
// Free range table storage: one write port, one read port, registered read data.
// Depends on arpa_pkg.
`default_nettype none
module arpa_range_ram (
  input  wire                      clk_i,
  input  wire                      we_i,
  input  wire [arpa_pkg::IdxW-1:0] waddr_i,
  input  arpa_pkg::range_t         wdata_i,
  input  wire [arpa_pkg::IdxW-1:0] raddr_i,
  output arpa_pkg::range_t         rdata_o
);
  import arpa_pkg::*;

  range_t mem_q [MaxRanges];
  range_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule
`default_nettype wire
